### src/tst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;

	localparam logic [2:0] OP_INGRESS       = 3'd0;
	localparam logic [2:0] OP_EGRESS        = 3'd1;
	localparam logic [2:0] OP_SET_PORT      = 3'd2;
	localparam logic [2:0] OP_CLEAR_PORT    = 3'd3;
	localparam logic [2:0] OP_SET_POL_REC   = 3'd4;
	localparam logic [2:0] OP_SET_POL_OTHER = 3'd5;
	localparam logic [2:0] OP_CLEAR_POL     = 3'd6;

	localparam logic [1:0] VERDICT_NONE = 2'd0;
	localparam logic [1:0] VERDICT_TCP  = 2'd1;
	localparam logic [1:0] VERDICT_HTTP = 2'd2;

	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_INSERTED = 2'd1;
	localparam logic [1:0] ACT_STAMPED  = 2'd2;
	localparam logic [1:0] ACT_DROPPED  = 2'd3;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_REQUEST  = 2'd1;
	localparam logic [1:0] KIND_RESPONSE = 2'd2;

	localparam logic [15:0] ETH_TYPE_IPV4      = 16'h0800;
	localparam logic [7:0]  PROTO_TCP          = 8'd6;
	localparam logic [3:0]  PLAIN_HEADER_WORDS = 4'd5;

	localparam int POL_VALID_BIT  = 0;
	localparam int POL_RECORD_BIT = 1;

	localparam int IN_DATA_W  = 200;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 136;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  entry_index;
		logic        headers_complete;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [3:0]  ip_header_words;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic        finish_or_reset;
		logic [63:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] addresses;
		logic [31:0] ports;
		logic [63:0] request_time;
		logic [63:0] response_time;
	} slot_entry_t;

	typedef struct packed {
		logic clear_en;
		logic capture;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### src/tst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tst_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  tst_pkg::dp_status_t   status,
	output tst_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_RMW   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_next = ST_RMW;
			end
			ST_RMW: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
`default_nettype wire

### src/tst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tst_datapath #(
	parameter int SESSION_SLOTS  = 8192,
	parameter int PORT_ENTRIES   = 8,
	parameter int POLICY_ENTRIES = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  tst_pkg::in_item_t                  item,
	input  tst_pkg::ctrl_cmd_t                 cmd,
	output tst_pkg::dp_status_t                status,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [tst_pkg::OUT_DATA_W-1:0]     out_data
);

	localparam int SW = $clog2(SESSION_SLOTS);
	localparam longint unsigned RECIP_L =
		((64'd1 << 32) + longint'(SESSION_SLOTS) - 1) / longint'(SESSION_SLOTS);
	localparam logic [48:0] RECIP = 49'(RECIP_L);

	tst_pkg::in_item_t in_q;
	logic [15:0] h_fwd_q, h_swp_q, q_fwd_q, q_swp_q;

	logic [15:0] port_val_q [PORT_ENTRIES];
	logic        port_vld_q [PORT_ENTRIES];
	logic [31:0] pol_addr_q [POLICY_ENTRIES];
	logic [15:0] pol_port_q [POLICY_ENTRIES];
	logic [1:0]  pol_flags_q [POLICY_ENTRIES];

	tst_pkg::slot_entry_t slot_mem_q [SESSION_SLOTS];
	tst_pkg::slot_entry_t rd_q;
	logic [SW-1:0] clr_cnt_q;

	logic [1:0]  verdict_q, kind_q;
	logic [31:0] key_sip_q, key_dip_q;
	logic [15:0] key_sp_q, key_dp_q;
	logic [SW-1:0] slot_q;

	logic        out_valid_q;
	logic [1:0]  o_verdict_q, o_action_q;
	logic        o_dir_q;
	logic [63:0] o_req_q, o_resp_q;

	function automatic logic [15:0] fold16(input logic [31:0] a, input logic [31:0] b,
			input logic [15:0] c, input logic [15:0] d);
		logic [31:0] x;
		x = a ^ b ^ {c, d};
		return x[15:0] ^ x[31:16];
	endfunction

	function automatic logic [15:0] quot16(input logic [15:0] h);
		logic [48:0] p;
		p = 49'(h) * RECIP;
		return p[47:32];
	endfunction

	logic [15:0] hf, hs;
	assign hf = fold16(item.source_address, item.destination_address,
		item.source_port, item.destination_port);
	assign hs = fold16(item.destination_address, item.source_address,
		item.destination_port, item.source_port);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q    <= item;
			h_fwd_q <= hf;
			h_swp_q <= hs;
			q_fwd_q <= quot16(hf);
			q_swp_q <= quot16(hs);
		end
	end

	// table lookups
	logic known_dp, known_sp;
	always_comb begin
		known_dp = 1'b0;
		known_sp = 1'b0;
		for (int i = 0; i < PORT_ENTRIES; i++) begin
			if (port_vld_q[i] && port_val_q[i] == in_q.destination_port) known_dp = 1'b1;
			if (port_vld_q[i] && port_val_q[i] == in_q.source_port) known_sp = 1'b1;
		end
	end

	logic [1:0] ex_s, wc_s, ex_d, wc_d;
	logic       exf_s, wcf_s, exf_d, wcf_d;
	logic       rec_src, rec_dst;
	always_comb begin
		ex_s = '0; wc_s = '0; ex_d = '0; wc_d = '0;
		exf_s = 1'b0; wcf_s = 1'b0; exf_d = 1'b0; wcf_d = 1'b0;
		for (int i = POLICY_ENTRIES - 1; i >= 0; i--) begin
			if (pol_flags_q[i][tst_pkg::POL_VALID_BIT]) begin
				if (pol_addr_q[i] == in_q.source_address &&
						pol_port_q[i] == in_q.source_port) begin
					ex_s = pol_flags_q[i]; exf_s = 1'b1;
				end
				if (pol_addr_q[i] == '0 && pol_port_q[i] == in_q.source_port) begin
					wc_s = pol_flags_q[i]; wcf_s = 1'b1;
				end
				if (pol_addr_q[i] == in_q.destination_address &&
						pol_port_q[i] == in_q.destination_port) begin
					ex_d = pol_flags_q[i]; exf_d = 1'b1;
				end
				if (pol_addr_q[i] == '0 && pol_port_q[i] == in_q.destination_port) begin
					wc_d = pol_flags_q[i]; wcf_d = 1'b1;
				end
			end
		end
		rec_src = exf_s ? ex_s[tst_pkg::POL_RECORD_BIT]
			: (wcf_s && wc_s[tst_pkg::POL_RECORD_BIT]);
		rec_dst = exf_d ? ex_d[tst_pkg::POL_RECORD_BIT]
			: (wcf_d && wc_d[tst_pkg::POL_RECORD_BIT]);
	end

	logic       is_tcp;
	logic [1:0] verdict_c, kind_c;
	logic       swap_c;
	always_comb begin
		is_tcp = in_q.headers_complete && in_q.ether_type == tst_pkg::ETH_TYPE_IPV4 &&
			in_q.ip_protocol == tst_pkg::PROTO_TCP &&
			in_q.ip_header_words == tst_pkg::PLAIN_HEADER_WORDS;
		verdict_c = tst_pkg::VERDICT_NONE;
		kind_c    = tst_pkg::KIND_NONE;
		swap_c    = 1'b0;
		if (is_tcp && in_q.operation == tst_pkg::OP_INGRESS) begin
			if (known_dp) begin
				verdict_c = tst_pkg::VERDICT_HTTP;
				kind_c = in_q.finish_or_reset ? tst_pkg::KIND_RESPONSE
					: tst_pkg::KIND_REQUEST;
			end else begin
				swap_c    = 1'b1;
				verdict_c = rec_src ? tst_pkg::VERDICT_HTTP : tst_pkg::VERDICT_TCP;
				if (known_sp || (rec_src && in_q.finish_or_reset)) begin
					kind_c = tst_pkg::KIND_RESPONSE;
				end
			end
		end else if (is_tcp && in_q.operation == tst_pkg::OP_EGRESS) begin
			verdict_c = tst_pkg::VERDICT_TCP;
			if (known_sp) begin
				verdict_c = tst_pkg::VERDICT_HTTP;
				kind_c    = tst_pkg::KIND_RESPONSE;
				swap_c    = 1'b1;
			end else if (rec_dst) begin
				verdict_c = tst_pkg::VERDICT_HTTP;
				kind_c    = tst_pkg::KIND_REQUEST;
			end
		end
	end

	logic [31:0] rem_c;
	logic [SW-1:0] slot_c;
	assign rem_c = swap_c
		? (32'(h_swp_q) - 32'(q_swp_q) * 32'(SESSION_SLOTS))
		: (32'(h_fwd_q) - 32'(q_fwd_q) * 32'(SESSION_SLOTS));
	assign slot_c = rem_c[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			verdict_q <= verdict_c;
			kind_q    <= kind_c;
			slot_q    <= slot_c;
			key_sip_q <= swap_c ? in_q.destination_address : in_q.source_address;
			key_dip_q <= swap_c ? in_q.source_address : in_q.destination_address;
			key_sp_q  <= swap_c ? in_q.destination_port : in_q.source_port;
			key_dp_q  <= swap_c ? in_q.source_port : in_q.destination_port;
			rd_q      <= slot_mem_q[slot_c];
		end
	end

	// session read-modify-write
	logic hit;
	logic mem_we;
	tst_pkg::slot_entry_t wr_c;
	logic [1:0]  act_c;
	logic [63:0] req_c, resp_c;
	always_comb begin
		hit = rd_q.valid && rd_q.addresses == {key_sip_q, key_dip_q} &&
			rd_q.ports == {key_sp_q, key_dp_q};
		mem_we = 1'b0;
		wr_c   = rd_q;
		act_c  = tst_pkg::ACT_NONE;
		req_c  = '0;
		resp_c = '0;
		if (kind_q == tst_pkg::KIND_REQUEST) begin
			if (!rd_q.valid) begin
				mem_we = 1'b1;
				wr_c.valid         = 1'b1;
				wr_c.addresses     = {key_sip_q, key_dip_q};
				wr_c.ports         = {key_sp_q, key_dp_q};
				wr_c.request_time  = in_q.timestamp;
				wr_c.response_time = '0;
				act_c = tst_pkg::ACT_INSERTED;
				req_c = in_q.timestamp;
			end else if (!hit) begin
				act_c = tst_pkg::ACT_DROPPED;
			end
		end else if (kind_q == tst_pkg::KIND_RESPONSE && hit) begin
			mem_we = 1'b1;
			wr_c.response_time = in_q.timestamp;
			act_c  = tst_pkg::ACT_STAMPED;
			req_c  = rd_q.request_time;
			resp_c = in_q.timestamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			slot_mem_q[clr_cnt_q] <= '0;
		end else if (cmd.commit && mem_we) begin
			slot_mem_q[slot_q] <= wr_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign status.clear_last = clr_cnt_q == SW'(SESSION_SLOTS - 1);
	assign status.out_free   = !out_valid_q || out_ready;

	// small tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_ENTRIES; i++) begin
				port_val_q[i] <= '0;
				port_vld_q[i] <= 1'b0;
			end
			for (int i = 0; i < POLICY_ENTRIES; i++) begin
				pol_addr_q[i]  <= '0;
				pol_port_q[i]  <= '0;
				pol_flags_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < PORT_ENTRIES; i++) begin
				if (in_q.entry_index == 4'(i)) begin
					if (in_q.operation == tst_pkg::OP_SET_PORT) begin
						port_vld_q[i] <= 1'b1;
						port_val_q[i] <= in_q.source_port;
					end else if (in_q.operation == tst_pkg::OP_CLEAR_PORT) begin
						port_vld_q[i] <= 1'b0;
						port_val_q[i] <= '0;
					end
				end
			end
			for (int i = 0; i < POLICY_ENTRIES; i++) begin
				if (in_q.entry_index == 4'(i) &&
						(in_q.operation == tst_pkg::OP_SET_POL_REC ||
						in_q.operation == tst_pkg::OP_SET_POL_OTHER ||
						in_q.operation == tst_pkg::OP_CLEAR_POL)) begin
					pol_addr_q[i]  <= in_q.source_address;
					pol_port_q[i]  <= in_q.destination_port;
					pol_flags_q[i] <= (in_q.operation == tst_pkg::OP_SET_POL_REC) ? 2'b11
						: (in_q.operation == tst_pkg::OP_SET_POL_OTHER) ? 2'b01 : 2'b00;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_verdict_q <= verdict_q;
			o_dir_q     <= verdict_q == tst_pkg::VERDICT_HTTP &&
				in_q.operation == tst_pkg::OP_INGRESS;
			o_action_q  <= act_c;
			o_req_q     <= req_c;
			o_resp_q    <= resp_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, o_resp_q, o_req_q, o_action_q, o_dir_q,
		o_verdict_q == tst_pkg::VERDICT_HTTP, o_verdict_q};

endmodule
`default_nettype wire

### src/tcp_session_timing_tracker.sv
// TCP session timing tracker: one packet-header or table-write transaction in,
// one verdict transaction out. Each transaction passes in turn through capture,
// table lookup with session memory read, and session read-modify-write; a new
// transaction is taken only after the last one commits, and the commit waits
// while the output register is full and the sink stalls. After reset the
// session memory is swept clear, one slot a cycle, before s_axis_tready first
// rises.
`timescale 1ns / 1ps
`default_nettype none
module tcp_session_timing_tracker #(
	parameter int SESSION_SLOTS  = 8192,
	parameter int PORT_ENTRIES   = 8,
	parameter int POLICY_ENTRIES = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_index, headers_complete, ether_type, ip_protocol, ip_header_words,
	// source_address, destination_address, source_port, destination_port,
	// finish_or_reset, timestamp
	input  wire  [tst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// operation
	input  wire  [tst_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// verdict, report_event, event_direction, session_action, request_time,
	// response_time
	output logic [tst_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	tst_pkg::in_item_t   item;
	tst_pkg::ctrl_cmd_t  cmd;
	tst_pkg::dp_status_t status;

	assign item.operation           = s_axis_tuser;
	assign item.entry_index         = s_axis_tdata[3:0];
	assign item.headers_complete    = s_axis_tdata[4];
	assign item.ether_type          = s_axis_tdata[20:5];
	assign item.ip_protocol         = s_axis_tdata[28:21];
	assign item.ip_header_words     = s_axis_tdata[32:29];
	assign item.source_address      = s_axis_tdata[64:33];
	assign item.destination_address = s_axis_tdata[96:65];
	assign item.source_port         = s_axis_tdata[112:97];
	assign item.destination_port    = s_axis_tdata[128:113];
	assign item.finish_or_reset     = s_axis_tdata[129];
	assign item.timestamp           = s_axis_tdata[193:130];

	tst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tst_datapath #(
		.SESSION_SLOTS  (SESSION_SLOTS),
		.PORT_ENTRIES   (PORT_ENTRIES),
		.POLICY_ENTRIES (POLICY_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("transaction accepted while busy");

	a_report_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2] == (m_axis_tdata[1:0] == tst_pkg::VERDICT_HTTP))
		else $error("report flag disagrees with verdict");

	a_action_needs_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5:4] != tst_pkg::ACT_NONE
			|-> m_axis_tdata[1:0] != tst_pkg::VERDICT_NONE)
		else $error("session action on non-TCP transaction");

	a_no_commit_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status.out_free)
		else $error("result overwritten");

endmodule
`default_nettype wire
